>>> hw/rtl/cartesian_to_polar_core_assert.svh
// Assertion macros for the cartesian to polar core.
// Used by cartesian_to_polar_core; no other dependencies.
`ifndef CARTESIAN_TO_POLAR_CORE_ASSERT_SVH
`define CARTESIAN_TO_POLAR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define C2P_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("c2p: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted
`define C2P_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("c2p: next-cycle property failed");

`endif

>>> hw/rtl/c2p_pkg.sv
// Shared constants, types and elaboration functions for the cartesian to polar core.
// No dependencies.
`timescale 1ns / 1ps

package c2p_pkg;

    // Extra fraction bits carried through the rotation datapath
    localparam int GUARD_BITS = 8;
    // Entries in the arctangent table
    localparam int TABLE_SIZE = 32;
    // Half a turn in the 32-bit angle accumulator
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest
    localparam logic [31:0] ATAN_TURNS [TABLE_SIZE] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Control that travels with each word down the pipeline
    typedef struct packed {
        logic valid;
        logic zero;
    } c2p_ctl_t;

    // Product of (1 + 4^-i) over the first n micro-rotations, in Q60
    function automatic logic [63:0] c2p_gain_product(input int n);
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (i < n) begin
                p = p + (p >> (2 * i));
            end
        end
        return p;
    endfunction

    // Integer square root, digit by digit (elaboration only)
    function automatic logic [63:0] c2p_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem  = v;
        root = 64'd0;
        b    = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (b > rem) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
        end
        return root;
    endfunction

endpackage

>>> hw/rtl/c2p_ifs.sv
// Valid/ready channel interfaces of the cartesian to polar core.
// No dependencies.
`timescale 1ns / 1ps

// Point pair channel: start and end point, signed Q16.16
interface c2p_point_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;

    modport source (output valid, output first_x, output first_y,
                    output second_x, output second_y, input ready);
    modport sink   (input valid, input first_x, input first_y,
                    input second_x, input second_y, output ready);
endinterface

// Polar result channel: distance (unsigned Q17.16) and binary angle heading
interface c2p_polar_if #(parameter int COORD_WIDTH = 32, parameter int ANGLE_WIDTH = 16);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH:0]   distance;
    logic [ANGLE_WIDTH-1:0] heading;

    modport source (output valid, output distance, output heading, input ready);
    modport sink   (input valid, input distance, input heading, output ready);
endinterface

>>> hw/rtl/cartesian_to_polar_core.sv
// Top level of the cartesian to polar core: pre-rotation, CORDIC cell chain, gain stage.
// Depends on c2p_pkg, c2p_ifs, c2p_prerot, c2p_cell, c2p_scale and the assertion header.
//
//  channel   dir   handshake      payload
//  points    in    valid/ready    first_x, first_y, second_x, second_y (signed Q16.16)
//  polar     out   valid/ready    distance (unsigned Q17.16), heading (binary angle)
//
// One point pair per cycle while the output is not stalled; the registers are the front register,
// one cell per micro-rotation, and two gain stages (split product, then sum).
// Every stage has its own valid bit; reset clears those, not the datapath.
// A stage takes a word when it is empty or its neighbor takes its word, so a
// stalled output still lets words fill bubbles further up.
`timescale 1ns / 1ps
`include "cartesian_to_polar_core_assert.svh"

module cartesian_to_polar_core
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16,
    parameter int ITERATIONS  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    c2p_point_if.sink    points,
    c2p_polar_if.source  polar
);

    localparam int STAGES     = (ITERATIONS > TABLE_SIZE) ? TABLE_SIZE : ITERATIONS;
    localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS + 3;
    localparam int MAG_WIDTH  = DATA_WIDTH - 1;

    c2p_ctl_t                     stage_ctl   [STAGES+1];
    logic signed [DATA_WIDTH-1:0] stage_x     [STAGES+1];
    logic signed [DATA_WIDTH-1:0] stage_y     [STAGES+1];
    logic [31:0]                  stage_acc   [STAGES+1];
    logic                         stage_ready [STAGES+1];
    c2p_ctl_t                     out_ctl;
    logic [MAG_WIDTH-1:0]         tail_mag;

    // Difference vector and half-turn flip
    c2p_prerot #(
        .COORD_WIDTH (COORD_WIDTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_prerot (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .ctl      (stage_ctl[0]),
        .x        (stage_x[0]),
        .y        (stage_y[0]),
        .acc      (stage_acc[0]),
        .ready_in (stage_ready[0])
    );

    // Chain of micro-rotation cells
    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        c2p_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .STAGE      (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl_in    (stage_ctl[k]),
            .x_in      (stage_x[k]),
            .y_in      (stage_y[k]),
            .acc_in    (stage_acc[k]),
            .ready_out (stage_ready[k]),
            .ctl_out   (stage_ctl[k+1]),
            .x_out     (stage_x[k+1]),
            .y_out     (stage_y[k+1]),
            .acc_out   (stage_acc[k+1]),
            .ready_in  (stage_ready[k+1])
        );
    end

    // Final x is non-negative; drop its sign bit
    assign tail_mag = stage_x[STAGES][MAG_WIDTH-1:0];

    // Gain compensation and output register
    c2p_scale #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .MAG_WIDTH   (MAG_WIDTH),
        .STAGES      (STAGES)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (stage_ctl[STAGES]),
        .mag_in    (tail_mag),
        .acc_in    (stage_acc[STAGES]),
        .ready_out (stage_ready[STAGES]),
        .ctl_out   (out_ctl),
        .polar     (polar)
    );

    // Coincident points are flagged in the cycle after acceptance
    `C2P_ASSERT_NEXT(a_zero_detect, clk, rst_n, points.valid && points.ready, stage_ctl[0].valid && (stage_ctl[0].zero == $past(points.first_x == points.second_x && points.first_y == points.second_y)))
    // A flagged word leaves with zero distance and zero heading
    `C2P_ASSERT_IMPLIES(a_zero_result, clk, rst_n, polar.valid && out_ctl.zero, polar.distance == '0 && polar.heading == '0)
    // The last cell holds its word while the gain stage is full
    `C2P_ASSERT_NEXT(a_tail_hold, clk, rst_n, stage_ctl[STAGES].valid && !stage_ready[STAGES], stage_ctl[STAGES].valid && $stable(stage_x[STAGES]))

endmodule

>>> hw/rtl/c2p_prerot.sv
// Front stage: difference vector, guard-bit scaling and half-turn pre-rotation.
// Depends on c2p_pkg and c2p_point_if.
`timescale 1ns / 1ps

module c2p_prerot
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int DATA_WIDTH  = 43
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    c2p_point_if.sink                    points,
    output c2p_ctl_t                     ctl,
    output logic signed [DATA_WIDTH-1:0] x,
    output logic signed [DATA_WIDTH-1:0] y,
    output logic [31:0]                  acc,
    input  logic                         ready_in
);

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int EXT_WIDTH  = DATA_WIDTH - DIFF_WIDTH;

    c2p_ctl_t                      ctl_reg;
    logic signed [DATA_WIDTH-1:0]  x_reg;
    logic signed [DATA_WIDTH-1:0]  y_reg;
    logic [31:0]                   acc_reg;
    logic signed [DATA_WIDTH-1:0]  x_next;
    logic signed [DATA_WIDTH-1:0]  y_next;
    logic [31:0]                   acc_next;
    logic signed [DIFF_WIDTH-1:0]  dx_fwd;
    logic signed [DIFF_WIDTH-1:0]  dx_rev;
    logic signed [DIFF_WIDTH-1:0]  dy_fwd;
    logic signed [DIFF_WIDTH-1:0]  dy_rev;
    logic signed [DIFF_WIDTH-1:0]  dx_sel;
    logic signed [DIFF_WIDTH-1:0]  dy_sel;
    logic                          load;

    // Take a new word whenever the stage is empty or draining
    assign load         = !ctl_reg.valid || ready_in;
    assign points.ready = load;

    // Form both differences so the half-turn flip needs no negation after
    always_comb
    begin
        dx_fwd = $signed({points.second_x[COORD_WIDTH-1], points.second_x})
               - $signed({points.first_x[COORD_WIDTH-1], points.first_x});
        dx_rev = $signed({points.first_x[COORD_WIDTH-1], points.first_x})
               - $signed({points.second_x[COORD_WIDTH-1], points.second_x});
        dy_fwd = $signed({points.second_y[COORD_WIDTH-1], points.second_y})
               - $signed({points.first_y[COORD_WIDTH-1], points.first_y});
        dy_rev = $signed({points.first_y[COORD_WIDTH-1], points.first_y})
               - $signed({points.second_y[COORD_WIDTH-1], points.second_y});
        dx_sel   = dx_fwd[DIFF_WIDTH-1] ? dx_rev : dx_fwd;
        dy_sel   = dx_fwd[DIFF_WIDTH-1] ? dy_rev : dy_fwd;
        acc_next = dx_fwd[DIFF_WIDTH-1] ? HALF_TURN : 32'd0;
        x_next   = $signed({{EXT_WIDTH{dx_sel[DIFF_WIDTH-1]}}, dx_sel}) <<< GUARD_BITS;
        y_next   = $signed({{EXT_WIDTH{dy_sel[DIFF_WIDTH-1]}}, dy_sel}) <<< GUARD_BITS;
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg.valid <= points.valid;
            ctl_reg.zero  <= (dx_fwd == '0) && (dy_fwd == '0);
        end
    end

    // Hold payload until the next word is taken
    always_ff @(posedge clk)
    begin
        if (load && points.valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign ctl = ctl_reg;
    assign x   = x_reg;
    assign y   = y_reg;
    assign acc = acc_reg;

endmodule

>>> hw/rtl/c2p_cell.sv
// One CORDIC vectoring micro-rotation with its own pipeline register.
// Depends on c2p_pkg.
`timescale 1ns / 1ps

module c2p_cell
    import c2p_pkg::*;
#(
    parameter int DATA_WIDTH = 43,
    parameter int STAGE      = 0
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  c2p_ctl_t                     ctl_in,
    input  logic signed [DATA_WIDTH-1:0] x_in,
    input  logic signed [DATA_WIDTH-1:0] y_in,
    input  logic [31:0]                  acc_in,
    output logic                         ready_out,
    output c2p_ctl_t                     ctl_out,
    output logic signed [DATA_WIDTH-1:0] x_out,
    output logic signed [DATA_WIDTH-1:0] y_out,
    output logic [31:0]                  acc_out,
    input  logic                         ready_in
);

    localparam logic [31:0] ATAN_STEP = ATAN_TURNS[STAGE];

    c2p_ctl_t                     ctl_reg;
    logic signed [DATA_WIDTH-1:0] x_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;
    logic [31:0]                  acc_reg;
    logic signed [DATA_WIDTH-1:0] x_next;
    logic signed [DATA_WIDTH-1:0] y_next;
    logic [31:0]                  acc_next;
    logic signed [DATA_WIDTH-1:0] x_shift;
    logic signed [DATA_WIDTH-1:0] y_shift;
    logic                         load;

    assign load      = !ctl_reg.valid || ready_in;
    assign ready_out = load;

    // Rotate toward the x axis; direction follows the sign of y
    always_comb
    begin
        x_shift = x_in >>> STAGE;
        y_shift = y_in >>> STAGE;
        if (!y_in[DATA_WIDTH-1])
        begin
            x_next   = x_in + y_shift;
            y_next   = y_in - x_shift;
            acc_next = acc_in + ATAN_STEP;
        end
        else
        begin
            x_next   = x_in - y_shift;
            y_next   = y_in + x_shift;
            acc_next = acc_in - ATAN_STEP;
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (load)
        begin
            ctl_reg <= ctl_in;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (load && ctl_in.valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;

endmodule

>>> hw/rtl/c2p_scale.sv
// Gain compensation, rounding and saturation of the distance; heading rounding.
// Depends on c2p_pkg and c2p_polar_if.
`timescale 1ns / 1ps

module c2p_scale
    import c2p_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_WIDTH = 16,
    parameter int MAG_WIDTH   = 42,
    parameter int STAGES      = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  c2p_ctl_t             ctl_in,
    input  logic [MAG_WIDTH-1:0] mag_in,
    input  logic [31:0]          acc_in,
    output logic                 ready_out,
    output c2p_ctl_t             ctl_out,
    c2p_polar_if.source          polar
);

    // Gain 1/prod(sqrt(1 + 4^-i)) in Q32
    localparam logic [63:0] GAIN_FULL =
        (64'd1 << 62) / c2p_isqrt(c2p_gain_product(STAGES));
    localparam logic [31:0] GAIN_Q32 = GAIN_FULL[31:0];

    // Magnitude split in halves so each product stays near 32x32
    localparam int LO_W       = (MAG_WIDTH + 1) / 2;
    localparam int HI_W       = MAG_WIDTH - LO_W;
    localparam int LOP_W      = LO_W + 33;
    localparam int HIP_W      = HI_W + 32;
    localparam int SUM_W      = MAG_WIDTH + 33;
    localparam int DROP       = 32 + GUARD_BITS;
    localparam int WIDE_W     = SUM_W - DROP;
    localparam int DIST_W     = COORD_WIDTH + 1;
    localparam logic [LOP_W-1:0] ROUND_ADD = LOP_W'(1) << (DROP - 1);
    localparam logic [32:0]      HEAD_HALF = (33'd1 << (32 - ANGLE_WIDTH)) >> 1;

    c2p_ctl_t               ctl1_reg;
    c2p_ctl_t               ctl2_reg;
    logic [LOP_W-1:0]       lo_prod_reg;
    logic [HIP_W-1:0]       hi_prod_reg;
    logic [ANGLE_WIDTH-1:0] head1_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic [ANGLE_WIDTH-1:0] head2_reg;
    logic [LO_W+31:0]       lo_prod;
    logic [HIP_W-1:0]       hi_prod;
    logic [LOP_W-1:0]       lo_prod_next;
    logic [32:0]            head_sum;
    logic [ANGLE_WIDTH-1:0] head_next;
    logic [SUM_W-1:0]       prod_sum;
    logic [WIDE_W-1:0]      dist_wide;
    logic [DIST_W-1:0]      dist_next;
    logic                   adv1;
    logic                   adv2;

    assign adv2      = !ctl2_reg.valid || polar.ready;
    assign adv1      = !ctl1_reg.valid || adv2;
    assign ready_out = adv1;

    // Stage 1: partial products with the rounding offset folded in; round heading
    always_comb
    begin
        lo_prod      = {32'd0, mag_in[LO_W-1:0]} * {{LO_W{1'b0}}, GAIN_Q32};
        hi_prod      = {32'd0, mag_in[MAG_WIDTH-1:LO_W]} * {{HI_W{1'b0}}, GAIN_Q32};
        lo_prod_next = {1'b0, lo_prod} + ROUND_ADD;
        head_sum     = {1'b0, acc_in} + HEAD_HALF;
        head_next    = ctl_in.zero ? '0 : head_sum[32-ANGLE_WIDTH +: ANGLE_WIDTH];
    end

    // Stage 2: sum partial products, drop fraction bits, saturate
    always_comb
    begin
        prod_sum  = SUM_W'({hi_prod_reg, {LO_W{1'b0}}}) + SUM_W'(lo_prod_reg);
        dist_wide = prod_sum[SUM_W-1:DROP];
        if (|dist_wide[WIDE_W-1:DIST_W])
        begin
            dist_next = '1;
        end
        else
        begin
            dist_next = dist_wide[DIST_W-1:0];
        end
    end

    // Advance control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            if (adv1)
            begin
                ctl1_reg <= ctl_in;
            end
            if (adv2)
            begin
                ctl2_reg <= ctl1_reg;
            end
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (adv1 && ctl_in.valid)
        begin
            lo_prod_reg <= lo_prod_next;
            hi_prod_reg <= hi_prod;
            head1_reg   <= head_next;
        end
        if (adv2 && ctl1_reg.valid)
        begin
            dist_reg  <= dist_next;
            head2_reg <= head1_reg;
        end
    end

    assign ctl_out        = ctl2_reg;
    assign polar.valid    = ctl2_reg.valid;
    assign polar.distance = dist_reg;
    assign polar.heading  = head2_reg;

endmodule

>>> verif/tb_cartesian_to_polar_core.sv
// Testbench for cartesian_to_polar_core: streams point pairs, predicts distance and heading.
// Depends on c2p_ifs (point and polar channels) and the core RTL.
`timescale 1ns / 1ps

module tb_cartesian_to_polar_core;

    localparam int COORD_WIDTH = 32;
    localparam int ANGLE_WIDTH = 16;
    localparam int ITERATIONS  = 16;
    localparam int ROTATIONS   = (ITERATIONS > 32) ? 32 : ITERATIONS;
    localparam int FRAC_GUARD  = 8;
    localparam int LATENCY     = ITERATIONS + 3;
    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT = 2000;

    localparam logic [32:0] DIST_MAX  = {33{1'b1}};
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] ONE   = 32'sh0001_0000;

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] STEP_ANGLE [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
    } point_pair_t;

    typedef struct packed {
        logic [32:0] distance;
        logic [15:0] heading;
    } polar_word_t;

    logic clk = 1'b0;
    logic rst_n;

    c2p_point_if #(.COORD_WIDTH(COORD_WIDTH)) pair_bus ();
    c2p_polar_if #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) polar_bus ();

    cartesian_to_polar_core #(
        .COORD_WIDTH(COORD_WIDTH),
        .ANGLE_WIDTH(ANGLE_WIDTH),
        .ITERATIONS (ITERATIONS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .points(pair_bus),
        .polar (polar_bus)
    );

    always #5 clk = ~clk;

    polar_word_t expected_polar [$];
    logic [63:0] cordic_gain;
    int          error_count;
    int          pairs_sent;
    int          words_checked;
    int          coincident_seen;
    bit          src_gaps;
    bit          rx_stalls;
    int          rx_hold_request;

    // Gain compensation factor in Q32, from the product of (1 + 4^-i)
    function automatic logic [63:0] compute_gain_q32();
        logic [63:0] prod;
        logic [63:0] root;
        logic [63:0] trial;
        prod = 64'd1 << 60;
        for (int i = 0; i < ROTATIONS; i++)
        begin
            prod = prod + (prod >> (2 * i));
        end
        root = 64'd0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= prod)
            begin
                root = trial;
            end
        end
        return (64'd1 << 62) / root;
    endfunction

    // Distance and heading of the vector from the first to the second point
    function automatic polar_word_t predict_polar(input point_pair_t p);
        longint      dx;
        longint      dy;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] acc;
        logic [63:0] xu;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] dist_full;
        logic [63:0] hsum;
        polar_word_t r;
        dx = longint'($signed(p.second_x)) - longint'($signed(p.first_x));
        dy = longint'($signed(p.second_y)) - longint'($signed(p.first_y));
        r = '0;
        if (dx == 0 && dy == 0)
        begin
            return r;
        end
        x = dx * (64'sd1 <<< FRAC_GUARD);
        y = dy * (64'sd1 <<< FRAC_GUARD);
        acc = 32'd0;
        // Fold the left half-plane onto the right one
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = HALF_TURN;
        end
        // Drive y to zero, accumulating the rotation angle
        for (int i = 0; i < ROTATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                acc = acc + STEP_ANGLE[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc = acc - STEP_ANGLE[i];
            end
        end
        // Scale by the gain in two halves, round away the guard bits
        xu = x;
        lo = {32'd0, xu[31:0]} * cordic_gain;
        hi = (xu >> 32) * cordic_gain;
        dist_full = (hi + (lo >> 32) + (64'd1 << (FRAC_GUARD - 1))) >> FRAC_GUARD;
        r.distance = (dist_full > {31'd0, DIST_MAX}) ? DIST_MAX : dist_full[32:0];
        hsum = {32'd0, acc} + (64'd1 << (32 - ANGLE_WIDTH - 1));
        r.heading = hsum[31:16];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < 10)
        begin
            $display("%0t ERROR %s", $time, msg);
        end
        error_count++;
    endtask

    // Idle length: mostly short, now and then a long one
    function automatic int pick_idle_len();
        if ($urandom_range(0, 99) < 85)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic point_pair_t make_pair(input logic signed [31:0] fx,
                                              input logic signed [31:0] fy,
                                              input logic signed [31:0] sx,
                                              input logic signed [31:0] sy);
        point_pair_t p;
        p.first_x  = fx;
        p.first_y  = fy;
        p.second_x = sx;
        p.second_y = sy;
        return p;
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Mix of full-range, short, coincident, axis, diagonal and extreme pairs
    function automatic point_pair_t random_pair();
        point_pair_t p;
        int          k;
        logic [31:0] d;
        k = $urandom_range(0, 99);
        p.first_x  = $urandom;
        p.first_y  = $urandom;
        p.second_x = $urandom;
        p.second_y = $urandom;
        if (k < 50)
        begin
            p = p;
        end
        else if (k < 65)
        begin
            d = 32'd1 << $urandom_range(1, 20);
            p.second_x = p.first_x + ($urandom % d) - (d >> 1);
            p.second_y = p.first_y + ($urandom % d) - (d >> 1);
        end
        else if (k < 70)
        begin
            p.second_x = p.first_x;
            p.second_y = p.first_y;
        end
        else if (k < 80)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                p.second_y = p.first_y;
            end
            else
            begin
                p.second_x = p.first_x;
            end
        end
        else if (k < 88)
        begin
            d = $urandom >> $urandom_range(0, 31);
            p.second_x = p.first_x + d;
            p.second_y = ($urandom_range(0, 1) == 0) ? p.first_y + d : p.first_y - d;
        end
        else
        begin
            p = make_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
        end
        return p;
    endfunction

    // Offer one word after an optional gap, return once it is accepted
    task automatic send_pair(input point_pair_t p, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            pair_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        pair_bus.valid    <= 1'b1;
        pair_bus.first_x  <= p.first_x;
        pair_bus.first_y  <= p.first_y;
        pair_bus.second_x <= p.second_x;
        pair_bus.second_y <= p.second_y;
        @(posedge clk);
        while (!pair_bus.ready)
        begin
            @(posedge clk);
        end
        pairs_sent++;
    endtask

    function automatic int source_gap();
        if (!src_gaps || $urandom_range(0, 99) < 65)
        begin
            return 0;
        end
        return pick_idle_len();
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_pair(random_pair(), source_gap());
        end
    endtask

    // Drop valid and wait for every outstanding word to come back
    task automatic drain_results();
        @(negedge clk);
        pair_bus.valid <= 1'b0;
        while (expected_polar.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Axes, diagonals, tiny steps, wrap just below +x, extremes, bit patterns
    task automatic test_directed_cases();
        point_pair_t cases [$];
        cases.push_back(make_pair(0, 0, 0, 0));
        cases.push_back(make_pair(C_MAX, C_MAX, C_MAX, C_MAX));
        cases.push_back(make_pair(C_MIN, C_MIN, C_MIN, C_MIN));
        cases.push_back(make_pair(0, 0, ONE, 0));
        cases.push_back(make_pair(0, 0, 0, ONE));
        cases.push_back(make_pair(0, 0, -ONE, 0));
        cases.push_back(make_pair(0, 0, 0, -ONE));
        cases.push_back(make_pair(0, 0, ONE, ONE));
        cases.push_back(make_pair(0, 0, -ONE, ONE));
        cases.push_back(make_pair(0, 0, -ONE, -ONE));
        cases.push_back(make_pair(0, 0, ONE, -ONE));
        cases.push_back(make_pair(0, 0, 1, 0));
        cases.push_back(make_pair(0, 0, -1, 0));
        cases.push_back(make_pair(0, 0, 0, -1));
        cases.push_back(make_pair(0, 0, C_MAX, -1));
        cases.push_back(make_pair(C_MIN, C_MIN, C_MAX, C_MAX));
        cases.push_back(make_pair(C_MAX, C_MIN, C_MIN, C_MAX));
        cases.push_back(make_pair(C_MAX, 0, C_MIN, 0));
        cases.push_back(make_pair(C_MIN, C_MAX, C_MAX, C_MIN));
        cases.push_back(make_pair(32'sh5555_5555, 32'shAAAA_AAAA,
                                  32'shAAAA_AAAA, 32'sh5555_5555));
        cases.push_back(make_pair(32'shAAAA_AAAA, 32'sh5555_5555,
                                  32'sh5555_5555, 32'shAAAA_AAAA));
        cases.push_back(make_pair(-1, -1, 0, 0));
        foreach (cases[i])
        begin
            send_pair(cases[i], (i % 3 == 2) ? 1 : 0);
        end
    endtask

    // Back-to-back words, receiver always ready
    task automatic test_steady_stream();
        src_gaps  = 1'b0;
        rx_stalls = 1'b0;
        send_random(250);
    endtask

    // Random gaps on each side alone, then on both
    task automatic test_idle_mix();
        src_gaps  = 1'b1;
        rx_stalls = 1'b0;
        send_random(230);
        src_gaps  = 1'b0;
        rx_stalls = 1'b1;
        send_random(230);
        src_gaps  = 1'b1;
        send_random(240);
    endtask

    // Long receiver hold while the sender keeps offering: pipeline fills and stalls
    task automatic test_output_backpressure();
        src_gaps  = 1'b0;
        rx_stalls = 1'b0;
        rx_hold_request = HOLD_CYCLES;
        send_random(60);
    endtask

    // Sender pauses until every result is back, then resumes
    task automatic test_drain_pause();
        src_gaps  = 1'b1;
        rx_stalls = 1'b1;
        send_random(60);
        drain_results();
        send_random(60);
    endtask

    // Receiver: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        polar_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                polar_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                polar_bus.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_stalls && $urandom_range(0, 99) < 25)
            begin
                stall_left = pick_idle_len() - 1;
                polar_bus.ready <= 1'b0;
            end
            else
            begin
                polar_bus.ready <= 1'b1;
            end
        end
    end

    // Check each result word against the oldest expectation, then queue new ones
    always @(posedge clk)
    begin : scoreboard
        polar_word_t want;
        point_pair_t got_pair;
        if (rst_n)
        begin
            if (polar_bus.valid && polar_bus.ready)
            begin
                words_checked++;
                if (expected_polar.size() == 0)
                begin
                    flag_error($sformatf("unexpected word distance=%0d heading=%0d",
                                         polar_bus.distance, polar_bus.heading));
                end
                else
                begin
                    want = expected_polar.pop_front();
                    if (polar_bus.distance !== want.distance ||
                        polar_bus.heading !== want.heading)
                    begin
                        flag_error($sformatf(
                            "distance exp %0d got %0d, heading exp %0d got %0d",
                            want.distance, polar_bus.distance,
                            want.heading, polar_bus.heading));
                    end
                end
            end
            if (pair_bus.valid && pair_bus.ready)
            begin
                got_pair = make_pair(pair_bus.first_x, pair_bus.first_y,
                                     pair_bus.second_x, pair_bus.second_y);
                if (got_pair.first_x == got_pair.second_x &&
                    got_pair.first_y == got_pair.second_y)
                begin
                    coincident_seen++;
                end
                expected_polar.push_back(predict_polar(got_pair));
            end
        end
    end

    // End the run when no word moves on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pair_bus.valid && pair_bus.ready) ||
                (polar_bus.valid && polar_bus.ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("tb_cartesian_to_polar_core: done, errors");
        $finish;
    end

    initial
    begin : main
        rst_n             = 1'b0;
        pair_bus.valid    = 1'b0;
        pair_bus.first_x  = '0;
        pair_bus.first_y  = '0;
        pair_bus.second_x = '0;
        pair_bus.second_y = '0;
        src_gaps          = 1'b0;
        rx_stalls         = 1'b0;
        rx_hold_request   = 0;
        error_count       = 0;
        pairs_sent        = 0;
        words_checked     = 0;
        coincident_seen   = 0;
        cordic_gain       = compute_gain_q32();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_steady_stream();
        test_idle_mix();
        test_output_backpressure();
        test_drain_pause();

        // Let the pipeline settle and catch any stray words
        drain_results();
        repeat (2 * LATENCY) @(posedge clk);
        if (expected_polar.size() != 0)
        begin
            flag_error($sformatf("%0d expected words never arrived", expected_polar.size()));
        end

        $display("covered %0d point pairs (%0d coincident), %0d polar words checked",
                 pairs_sent, coincident_seen, words_checked);
        $display("idling: steady stream, gaps on each side, %0d-cycle output hold, full drain",
                 HOLD_CYCLES);
        if (error_count == 0)
        begin
            $display("tb_cartesian_to_polar_core: done, clean");
        end
        else
        begin
            $display("%0d errors", error_count);
            $display("tb_cartesian_to_polar_core: done, errors");
        end
        $finish;
    end

endmodule
